@@ rtl/psmq_pkg.sv @@
// Package for the paced speech message queue: FSM state, result codes,
// register indexes, reset values and controller/datapath command structs.
// No dependencies.
package psmq_pkg;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SPEED,
      S_MSG_START,
      S_MSG
   } state_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_MSG    = 2'd1,
      KIND_SPEED  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ENQ_ACCEPTED = 2'd0,
      ENQ_FULL     = 2'd1,
      ENQ_TOO_LONG = 2'd2
   } enq_status_type;

   typedef enum logic [2:0] {
      CFG_SPEED_ON_START   = 3'd0,
      CFG_START_TIME_MS    = 3'd1,
      CFG_STARTUP_DELAY_MS = 3'd2,
      CFG_SETTLE_MS        = 3'd3,
      CFG_BASE_SPEECH_MS   = 3'd4,
      CFG_PER_CHAR_MS      = 3'd5
   } cfg_index_type;

   localparam int CFG_INDEX_W = 3;
   localparam int DUR_W       = 19;

   localparam logic        RST_SPEED_ON_START   = 1'b1;
   localparam logic [15:0] RST_STARTUP_DELAY_MS = 16'd500;
   localparam logic [15:0] RST_SETTLE_MS        = 16'd300;
   localparam logic [15:0] RST_BASE_SPEECH_MS   = 16'd300;
   localparam logic [11:0] RST_PER_CHAR_MS      = 12'd180;

   // GB2312 lead / trail byte ranges
   localparam logic [7:0] GB_LO      = 8'hA1;
   localparam logic [7:0] GB_LEAD_HI = 8'hF7;
   localparam logic [7:0] GB_TRAIL_HI = 8'hFE;

   // Speed command "<S>3"
   function automatic logic [7:0] speed_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0:    b = 8'h3C;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h3E;
         default: b = 8'h33;
      endcase
      return b;
   endfunction

   typedef struct packed {
      logic take_byte;
      logic take_tick;
      logic msg_start;
      logic msg_send;
      logic speed_send;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic speed_go;
      logic msg_go;
      logic speed_done;
      logic msg_done;
   } ctrl_stat_type;

endpackage

@@ rtl/psmq_ctrl.sv @@
// Controller FSM for the paced speech message queue.
// Sequences ticks into speed-command and message streams.
// Depends on psmq_pkg.
module psmq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   output logic                    req_ready,
   input  psmq_pkg::ctrl_stat_type stat,
   output psmq_pkg::ctrl_cmd_type  cmd
);

   psmq_pkg::state_type state_ff, state_in;
   logic                accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psmq_pkg::S_IDLE: begin
            if (accept && req_command) begin
               if (stat.speed_go) begin
                  state_in = psmq_pkg::S_SPEED;
               end else if (stat.msg_go) begin
                  state_in = psmq_pkg::S_MSG_START;
               end
            end
         end
         psmq_pkg::S_SPEED: begin
            if (stat.out_free && stat.speed_done) begin
               state_in = psmq_pkg::S_IDLE;
            end
         end
         psmq_pkg::S_MSG_START: begin
            state_in = psmq_pkg::S_MSG;
         end
         psmq_pkg::S_MSG: begin
            if (stat.out_free && stat.msg_done) begin
               state_in = psmq_pkg::S_IDLE;
            end
         end
         default: state_in = psmq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         psmq_pkg::S_IDLE: begin
            req_ready     = stat.out_free;
            cmd.take_byte = req_valid && stat.out_free && !req_command;
            cmd.take_tick = req_valid && stat.out_free && req_command;
         end
         psmq_pkg::S_SPEED:     cmd.speed_send = stat.out_free;
         psmq_pkg::S_MSG_START: cmd.msg_start  = 1'b1;
         psmq_pkg::S_MSG:       cmd.msg_send   = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psmq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/psmq_datapath.sv @@
// Datapath of the paced speech message queue: config registers, ring state,
// text and slot-info memories, character timing and the result register.
// Depends on psmq_pkg.
module psmq_datapath #(
   parameter int QUEUE_DEPTH   = 8,
   parameter int TEXT_CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [psmq_pkg::CFG_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_text_last,
   input  logic [31:0]                          req_now_ms,
   input  logic                                 req_sink_ready,
   input  psmq_pkg::ctrl_cmd_type               cmd,
   output psmq_pkg::ctrl_stat_type              stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic [7:0]                           rsp_data_byte,
   output logic                                 rsp_last,
   output logic [1:0]                           rsp_enqueue_status
);

   localparam int IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int LEN_W     = $clog2(TEXT_CAPACITY + 1);
   localparam int BYTE_W    = $clog2(TEXT_CAPACITY);
   localparam int MEM_DEPTH = QUEUE_DEPTH * TEXT_CAPACITY;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int DUR_W     = psmq_pkg::DUR_W;
   localparam int INFO_W    = LEN_W + DUR_W;

   localparam logic [CNT_W-1:0]  QD_CNT    = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0]  QD_SUM    = SUM_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [LEN_W-1:0]  CAP_LEN   = LEN_W'(TEXT_CAPACITY);
   localparam logic [ADDR_W-1:0] CAP_ADDR  = ADDR_W'(TEXT_CAPACITY);

   // configuration
   logic [31:0] start_ff, start_in;
   logic [15:0] delay_ff, delay_in;
   logic [31:0] deadline_ff, deadline_in;   // start + startup delay
   logic [15:0] settle_ff, settle_in;
   logic [15:0] base_ff, base_in;
   logic [11:0] pc_ff, pc_in;

   // ring and pacing state
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       busy_ff, busy_in;
   logic              speed_pending_ff, speed_pending_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              lead_ff, lead_in;
   logic [DUR_W-1:0]  accum_ff, accum_in;
   logic              overflow_ff, overflow_in;
   logic              drop_ff, drop_in;

   // streaming state
   logic [31:0]       now_ff, now_in;
   logic [1:0]        spd_cnt_ff, spd_cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] base_addr_ff, base_addr_in;
   logic [BYTE_W-1:0] idx_ff, idx_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   psmq_pkg::kind_type       rsp_kind_ff, rsp_kind_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   // memories
   logic [7:0]        text_mem [MEM_DEPTH];
   logic [INFO_W-1:0] info_mem [QUEUE_DEPTH];
   logic [7:0]        rdata_ff;
   logic [INFO_W-1:0] info_rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              text_we;
   logic              info_we;
   logic [INFO_W-1:0] info_wdata;

   // combinational helpers
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail;
   logic              queue_full;
   logic              fill_room;
   logic              is_lead, is_trail;
   logic              lead_nxt;
   logic [1:0]        char_inc, char_fin;
   logic [DUR_W-1:0]  char_ms;
   logic [DUR_W-1:0]  accum_nxt;
   logic [DUR_W-1:0]  dur_fin;
   logic              overflow_nxt, drop_nxt;
   psmq_pkg::enq_status_type enq_status;
   logic [31:0]       diff_busy, diff_start;
   logic              msg_done;
   logic [BYTE_W-1:0] next_idx;
   logic              out_free;

   assign tail_sum   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail       = (tail_sum >= QD_SUM) ? IDX_W'(tail_sum - QD_SUM) : IDX_W'(tail_sum);
   assign queue_full = (count_ff == QD_CNT);
   assign fill_room  = (fill_ff < CAP_LEN);
   assign is_lead    = (req_text_byte >= psmq_pkg::GB_LO) &&
                       (req_text_byte <= psmq_pkg::GB_LEAD_HI);
   assign is_trail   = (req_text_byte >= psmq_pkg::GB_LO) &&
                       (req_text_byte <= psmq_pkg::GB_TRAIL_HI);

   // character count for this byte; a pending lead that is not followed by a
   // trail counts on its own, and so does a lead left dangling at the end
   always_comb begin
      lead_nxt = lead_ff;
      char_inc = 2'd0;
      if (fill_room) begin
         if (lead_ff) begin
            lead_nxt = 1'b0;
            if (is_trail) begin
               char_inc = 2'd1;
            end else if (is_lead) begin
               lead_nxt = 1'b1;
               char_inc = 2'd1;
            end else begin
               char_inc = 2'd2;
            end
         end else if (is_lead) begin
            lead_nxt = 1'b1;
         end else begin
            char_inc = 2'd1;
         end
      end
      char_fin = char_inc + {1'b0, req_text_last && lead_nxt};
   end

   always_comb begin
      unique case (char_fin)
         2'd0:    char_ms = '0;
         2'd1:    char_ms = DUR_W'(pc_ff);
         default: char_ms = DUR_W'({pc_ff, 1'b0});
      endcase
   end

   assign accum_nxt    = accum_ff + char_ms;
   assign dur_fin      = accum_nxt + DUR_W'(base_ff);
   assign overflow_nxt = overflow_ff || !fill_room;
   assign drop_nxt     = drop_ff || (fill_room && queue_full);

   always_comb begin
      priority if (overflow_nxt) begin
         enq_status = psmq_pkg::ENQ_TOO_LONG;
      end else if (drop_nxt || queue_full) begin
         enq_status = psmq_pkg::ENQ_FULL;
      end else begin
         enq_status = psmq_pkg::ENQ_ACCEPTED;
      end
   end

   // wrap-safe deadline checks
   assign diff_busy  = req_now_ms - busy_ff;
   assign diff_start = req_now_ms - deadline_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign msg_done = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);
   assign next_idx = (cmd.msg_send && !msg_done) ? idx_ff + BYTE_W'(1) : idx_ff;

   assign stat.out_free   = out_free;
   assign stat.speed_go   = speed_pending_ff && !diff_busy[31] && !diff_start[31] &&
                            req_sink_ready;
   assign stat.msg_go     = !speed_pending_ff && !diff_busy[31] && (count_ff != '0) &&
                            req_sink_ready;
   assign stat.speed_done = (spd_cnt_ff == 2'd3);
   assign stat.msg_done   = msg_done;

   // memory ports
   assign wr_addr    = ADDR_W'(tail) * CAP_ADDR + ADDR_W'(fill_ff[BYTE_W-1:0]);
   assign text_we    = cmd.take_byte && fill_room && !queue_full;
   assign info_we    = cmd.take_byte && req_text_last && (enq_status == psmq_pkg::ENQ_ACCEPTED);
   assign info_wdata = {fill_ff + LEN_W'(1), dur_fin};
   assign rd_addr    = cmd.msg_start ? ADDR_W'(head_ff) * CAP_ADDR
                                     : base_addr_ff + ADDR_W'(next_idx);

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[wr_addr] <= req_text_byte;
      end
      rdata_ff <= text_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[tail] <= info_wdata;
      end
      info_rd_ff <= info_mem[head_ff];
   end

   always_comb begin
      start_in         = start_ff;
      delay_in         = delay_ff;
      deadline_in      = deadline_ff;
      settle_in        = settle_ff;
      base_in          = base_ff;
      pc_in            = pc_ff;
      head_in          = head_ff;
      count_in         = count_ff;
      busy_in          = busy_ff;
      speed_pending_in = speed_pending_ff;
      fill_in          = fill_ff;
      lead_in          = lead_ff;
      accum_in         = accum_ff;
      overflow_in      = overflow_ff;
      drop_in          = drop_ff;
      now_in           = now_ff;
      spd_cnt_in       = spd_cnt_ff;
      len_in           = len_ff;
      base_addr_in     = base_addr_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_status_in    = rsp_status_ff;

      if (cmd.take_byte) begin
         if (req_text_last) begin
            if (enq_status == psmq_pkg::ENQ_ACCEPTED) begin
               count_in = count_ff + CNT_W'(1);
            end
            fill_in       = '0;
            lead_in       = 1'b0;
            accum_in      = '0;
            overflow_in   = 1'b0;
            drop_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = psmq_pkg::KIND_STATUS;
            rsp_data_in   = 8'd0;
            rsp_last_in   = 1'b1;
            rsp_status_in = enq_status;
         end else begin
            overflow_in = overflow_nxt;
            drop_in     = drop_nxt;
            lead_in     = lead_nxt;
            accum_in    = accum_nxt;
            if (fill_room) begin
               fill_in = fill_ff + LEN_W'(1);
            end
         end
      end

      if (cmd.take_tick) begin
         now_in     = req_now_ms;
         spd_cnt_in = 2'd0;
         if (stat.speed_go) begin
            speed_pending_in = 1'b0;
            busy_in          = req_now_ms + 32'(settle_ff);
         end
      end

      if (cmd.speed_send) begin
         spd_cnt_in    = spd_cnt_ff + 2'd1;
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = psmq_pkg::KIND_SPEED;
         rsp_data_in   = psmq_pkg::speed_byte(spd_cnt_ff);
         rsp_last_in   = stat.speed_done;
         rsp_status_in = psmq_pkg::ENQ_ACCEPTED;
      end

      if (cmd.msg_start) begin
         len_in       = info_rd_ff[INFO_W-1:DUR_W];
         busy_in      = now_ff + 32'(info_rd_ff[DUR_W-1:0]);
         base_addr_in = ADDR_W'(head_ff) * CAP_ADDR;
         idx_in       = '0;
         head_in      = (head_ff == LAST_SLOT) ? '0 : head_ff + IDX_W'(1);
         count_in     = count_ff - CNT_W'(1);
      end

      if (cmd.msg_send) begin
         idx_in        = next_idx;
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = psmq_pkg::KIND_MSG;
         rsp_data_in   = rdata_ff;
         rsp_last_in   = msg_done;
         rsp_status_in = psmq_pkg::ENQ_ACCEPTED;
      end

      if (csr_we) begin
         unique case (csr_index)
            psmq_pkg::CFG_SPEED_ON_START: speed_pending_in = csr_wdata[0];
            psmq_pkg::CFG_START_TIME_MS: begin
               start_in    = csr_wdata;
               deadline_in = csr_wdata + 32'(delay_ff);
            end
            psmq_pkg::CFG_STARTUP_DELAY_MS: begin
               delay_in    = csr_wdata[15:0];
               deadline_in = start_ff + 32'(csr_wdata[15:0]);
            end
            psmq_pkg::CFG_SETTLE_MS:      settle_in = csr_wdata[15:0];
            psmq_pkg::CFG_BASE_SPEECH_MS: base_in   = csr_wdata[15:0];
            psmq_pkg::CFG_PER_CHAR_MS:    pc_in     = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff         <= '0;
         delay_ff         <= psmq_pkg::RST_STARTUP_DELAY_MS;
         deadline_ff      <= 32'(psmq_pkg::RST_STARTUP_DELAY_MS);
         settle_ff        <= psmq_pkg::RST_SETTLE_MS;
         base_ff          <= psmq_pkg::RST_BASE_SPEECH_MS;
         pc_ff            <= psmq_pkg::RST_PER_CHAR_MS;
         head_ff          <= '0;
         count_ff         <= '0;
         busy_ff          <= '0;
         speed_pending_ff <= psmq_pkg::RST_SPEED_ON_START;
         fill_ff          <= '0;
         lead_ff          <= 1'b0;
         accum_ff         <= '0;
         overflow_ff      <= 1'b0;
         drop_ff          <= 1'b0;
         spd_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_ff         <= start_in;
         delay_ff         <= delay_in;
         deadline_ff      <= deadline_in;
         settle_ff        <= settle_in;
         base_ff          <= base_in;
         pc_ff            <= pc_in;
         head_ff          <= head_in;
         count_ff         <= count_in;
         busy_ff          <= busy_in;
         speed_pending_ff <= speed_pending_in;
         fill_ff          <= fill_in;
         lead_ff          <= lead_in;
         accum_ff         <= accum_in;
         overflow_ff      <= overflow_in;
         drop_ff          <= drop_in;
         spd_cnt_ff       <= spd_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      len_ff        <= len_in;
      base_addr_ff  <= base_addr_in;
      idx_ff        <= idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_enqueue_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QD_CNT)
      else $error("message count above queue depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_SLOT)
      else $error("head index out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_LEN)
      else $error("fill index above text capacity");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.msg_start |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("message start did not pop the queue");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.msg_send || cmd.speed_send || (cmd.take_byte && req_text_last)) |->
      (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while holding an untaken result");
`endif

endmodule

@@ rtl/paced_speech_message_queue_unit.sv @@
// Top level of the paced speech message queue.
// Instantiates psmq_ctrl and psmq_datapath; depends on psmq_pkg.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    command, text_byte, text_last, now_ms,
//                                              sink_ready
//   rsp_     out        rsp_valid/rsp_ready    kind, data_byte, last, enqueue_status
//   csr_     in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Idle takes text bytes; the status for a final byte sits in the result register.
// A tick that sends nothing leaves the FSM idle; the speed command sends 4 bytes and a
// message its text after S_MSG_START, one byte per cycle out of the registered text
// memory read while no result waits; new transactions wait until a stream is done.
// Synchronous active-high reset; the text and slot-info memories need no clearing pass.
module paced_speech_message_queue_unit #(
   parameter int QUEUE_DEPTH   = 8,
   parameter int TEXT_CAPACITY = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [7:0]                       req_text_byte,
   input  logic                             req_text_last,
   input  logic [31:0]                      req_now_ms,
   input  logic                             req_sink_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [7:0]                       rsp_data_byte,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_enqueue_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psmq_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);

   psmq_pkg::ctrl_cmd_type  cmd;
   psmq_pkg::ctrl_stat_type stat;
   logic                    csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   psmq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   psmq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .TEXT_CAPACITY (TEXT_CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_text_byte      (req_text_byte),
      .req_text_last      (req_text_last),
      .req_now_ms         (req_now_ms),
      .req_sink_ready     (req_sink_ready),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_enqueue_status (rsp_enqueue_status)
   );

endmodule
